// File: src/cbl_pkg.sv
package cbl_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAME_BITS = 11;
  localparam int PIX_BITS   = 10;
  localparam int COLOR_BITS = 8;
  localparam int SKIP_BITS  = 8;
  localparam int FRAME_MAX  = 1024;
  // signed width that holds a coordinate and a frame bound side by side
  localparam int CMP_W      = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS) + 1;

  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } cbl_op_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cbl_reg_t;

  typedef struct packed {
    cbl_op_t                       op;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic [COLOR_BITS-1:0]         pen_color;
    logic [SKIP_BITS-1:0]          dash_skip;
    logic signed [COORD_BITS-1:0]  box_left;
    logic signed [COORD_BITS-1:0]  box_right;
    logic signed [COORD_BITS-1:0]  box_top;
    logic signed [COORD_BITS-1:0]  box_bottom;
  } cbl_in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]   pixel_x;
    logic [PIX_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  pixel_write;
    logic                  line_last;
  } cbl_out_t;

endpackage

// File: src/cbl_core.sv
module cbl_core
  import cbl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_take,
  input  cbl_in_t               in_beat,
  input  logic [FRAME_BITS-1:0] frame_w,
  input  logic [FRAME_BITS-1:0] frame_h,
  output logic                  res_valid,
  output cbl_out_t              res
);

  localparam int CB = COORD_BITS;

  logic                 line_active_r, line_active_nxt;
  logic signed [CB-1:0] cursor_x_r, cursor_x_nxt;
  logic signed [CB-1:0] cursor_y_r, cursor_y_nxt;
  logic [CB:0]          error_term_r, error_term_nxt;
  logic [CB-1:0]        delta_major_r, delta_major_nxt;
  logic [CB-1:0]        delta_minor_r, delta_minor_nxt;
  logic                 x_move_r, x_neg_r, y_move_r, y_neg_r;
  logic                 x_move_nxt, x_neg_nxt, y_move_nxt, y_neg_nxt;
  logic                 x_is_major_r, x_is_major_nxt;
  logic [CB-1:0]        steps_left_r, steps_left_nxt;
  logic [SKIP_BITS-1:0] dash_phase_r, dash_phase_nxt;
  logic [SKIP_BITS-1:0] dash_period_r, dash_period_nxt;
  logic [COLOR_BITS-1:0] line_color_r, line_color_nxt;
  logic signed [CB-1:0] box_left_r, box_right_r, box_top_r, box_bottom_r;
  logic signed [CB-1:0] box_left_nxt, box_right_nxt, box_top_nxt, box_bottom_nxt;

  // load path
  logic signed [CMP_W-1:0] fw_s, fh_s;
  logic signed [CMP_W-1:0] x1_e, y1_e, x2_e, y2_e;
  logic                    load_ok;
  logic signed [CB:0]      dx, dy;
  logic [CB:0]             ax_w, ay_w;
  logic [CB-1:0]           ax, ay;
  logic                    ld_x_major;
  logic [CB-1:0]           ld_major, ld_minor;

  // step path
  logic [CB:0]             err_sum;
  logic                    carry;
  logic                    step_x, step_y;
  logic signed [CB-1:0]    inc_x, inc_y;
  logic signed [CB-1:0]    nx, ny;
  logic signed [CMP_W-1:0] nx_e, ny_e;
  logic                    dash_on;
  logic [SKIP_BITS:0]      phase_inc;
  logic                    in_bounds;
  logic                    last;

  assign fw_s = signed'({{(CMP_W-FRAME_BITS){1'b0}}, frame_w});
  assign fh_s = signed'({{(CMP_W-FRAME_BITS){1'b0}}, frame_h});
  assign x1_e = CMP_W'(in_beat.start_x);
  assign y1_e = CMP_W'(in_beat.start_y);
  assign x2_e = CMP_W'(in_beat.end_x);
  assign y2_e = CMP_W'(in_beat.end_y);
  assign load_ok = !(x1_e > fw_s || x2_e > fw_s || y1_e > fh_s || y2_e > fh_s);

  assign dx   = (CB+1)'(in_beat.end_x) - (CB+1)'(in_beat.start_x);
  assign dy   = (CB+1)'(in_beat.end_y) - (CB+1)'(in_beat.start_y);
  assign ax_w = dx[CB] ? unsigned'(-dx) : unsigned'(dx);
  assign ay_w = dy[CB] ? unsigned'(-dy) : unsigned'(dy);
  assign ax   = ax_w[CB-1:0];
  assign ay   = ay_w[CB-1:0];
  assign ld_x_major = ax >= ay;
  assign ld_major   = ld_x_major ? ax : ay;
  assign ld_minor   = ld_x_major ? ay : ax;

  assign err_sum = error_term_r + {1'b0, delta_minor_r};
  assign carry   = err_sum >= {1'b0, delta_major_r};
  assign step_x  = x_move_r && (x_is_major_r || carry);
  assign step_y  = y_move_r && (!x_is_major_r || carry);
  assign inc_x   = step_x ? (x_neg_r ? -CB'(1) : CB'(1)) : '0;
  assign inc_y   = step_y ? (y_neg_r ? -CB'(1) : CB'(1)) : '0;
  assign nx      = cursor_x_r + inc_x;
  assign ny      = cursor_y_r + inc_y;
  assign nx_e    = CMP_W'(nx);
  assign ny_e    = CMP_W'(ny);

  assign dash_on   = dash_phase_r == '0;
  assign phase_inc = {1'b0, dash_phase_r} + (SKIP_BITS+1)'(1);

  assign in_bounds = nx >= box_left_r && nx <= box_right_r
                  && ny >= box_top_r  && ny <= box_bottom_r
                  && !nx_e[CMP_W-1] && nx_e < fw_s
                  && !ny_e[CMP_W-1] && ny_e < fh_s;

  assign last = steps_left_r <= CB'(1);

  assign res_valid = (in_beat.op == OP_STEP) && line_active_r;

  always_comb begin
    res.pixel_write = dash_on && in_bounds;
    res.pixel_x     = res.pixel_write ? nx_e[PIX_BITS-1:0] : '0;
    res.pixel_y     = res.pixel_write ? ny_e[PIX_BITS-1:0] : '0;
    res.pixel_color = line_color_r;
    res.line_last   = last;
  end

  always_comb begin
    line_active_nxt = line_active_r;
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    error_term_nxt  = error_term_r;
    delta_major_nxt = delta_major_r;
    delta_minor_nxt = delta_minor_r;
    x_move_nxt      = x_move_r;
    x_neg_nxt       = x_neg_r;
    y_move_nxt      = y_move_r;
    y_neg_nxt       = y_neg_r;
    x_is_major_nxt  = x_is_major_r;
    steps_left_nxt  = steps_left_r;
    dash_phase_nxt  = dash_phase_r;
    dash_period_nxt = dash_period_r;
    line_color_nxt  = line_color_r;
    box_left_nxt    = box_left_r;
    box_right_nxt   = box_right_r;
    box_top_nxt     = box_top_r;
    box_bottom_nxt  = box_bottom_r;
    if (in_take) begin
      if (in_beat.op == OP_LOAD) begin
        if (load_ok) begin
          line_active_nxt = ld_major != '0;
          cursor_x_nxt    = in_beat.start_x;
          cursor_y_nxt    = in_beat.start_y;
          error_term_nxt  = {2'b00, ld_major[CB-1:1]};
          delta_major_nxt = ld_major;
          delta_minor_nxt = ld_minor;
          x_move_nxt      = dx != '0;
          x_neg_nxt       = dx[CB];
          y_move_nxt      = dy != '0;
          y_neg_nxt       = dy[CB];
          x_is_major_nxt  = ld_x_major;
          steps_left_nxt  = ld_major;
          dash_phase_nxt  = '0;
          dash_period_nxt = (in_beat.dash_skip == '0) ? SKIP_BITS'(1) : in_beat.dash_skip;
          line_color_nxt  = in_beat.pen_color;
          box_left_nxt    = in_beat.box_left;
          box_right_nxt   = in_beat.box_right;
          box_top_nxt     = in_beat.box_top;
          box_bottom_nxt  = in_beat.box_bottom;
        end
      end else if (line_active_r) begin
        error_term_nxt  = carry ? err_sum - {1'b0, delta_major_r} : err_sum;
        cursor_x_nxt    = nx;
        cursor_y_nxt    = ny;
        dash_phase_nxt  = (phase_inc >= {1'b0, dash_period_r}) ? '0 : phase_inc[SKIP_BITS-1:0];
        steps_left_nxt  = steps_left_r - CB'(1);
        line_active_nxt = !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else begin
      line_active_r <= line_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_x_r    <= cursor_x_nxt;
    cursor_y_r    <= cursor_y_nxt;
    error_term_r  <= error_term_nxt;
    delta_major_r <= delta_major_nxt;
    delta_minor_r <= delta_minor_nxt;
    x_move_r      <= x_move_nxt;
    x_neg_r       <= x_neg_nxt;
    y_move_r      <= y_move_nxt;
    y_neg_r       <= y_neg_nxt;
    x_is_major_r  <= x_is_major_nxt;
    steps_left_r  <= steps_left_nxt;
    dash_phase_r  <= dash_phase_nxt;
    dash_period_r <= dash_period_nxt;
    line_color_r  <= line_color_nxt;
    box_left_r    <= box_left_nxt;
    box_right_r   <= box_right_nxt;
    box_top_r     <= box_top_nxt;
    box_bottom_r  <= box_bottom_nxt;
  end

endmodule

// File: src/clipped_bresenham_line_generator.sv
// Bresenham line generator with clip box and dash pattern. Send a load beat
// (op = load) with endpoints, color, dash period and clip box; it gives no
// output and is dropped when an endpoint lies beyond the frame bounds. Each
// following step beat advances one pixel along the major axis and returns one
// output beat with the pixel position, a write enable (dash phase, clip box
// and frame all pass) and a last-step flag; the start point is not drawn.
// Each step is one add-and-compare pass from the line state registers into
// the output register, so one beat is accepted per clock while the skid
// entry is empty. A two-entry output buffer keeps input flowing for one
// extra beat while the output side stalls. Frame width and height sit in
// the APB registers at byte addresses 0 and 4; bounds above 1024 act as 1024.
module clipped_bresenham_line_generator
  import cbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cbl_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cbl_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [FRAME_BITS-1:0] frame_width_r, frame_height_r;
  logic [FRAME_BITS-1:0] fw_eff, fh_eff;
  cbl_reg_t              reg_sel;
  logic                  cfg_wr;

  logic                  in_take;
  logic                  res_valid;
  cbl_out_t              res;
  logic                  push, pop;

  logic                  out_valid_r, out_valid_nxt;
  cbl_out_t              out_data_r, out_data_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  cbl_out_t              skid_data_r, skid_data_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cbl_reg_t'(cfg_paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DW'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DW'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_BITS'(320);
      frame_height_r <= FRAME_BITS'(200);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[FRAME_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign fw_eff = (frame_width_r  > FRAME_BITS'(FRAME_MAX)) ? FRAME_BITS'(FRAME_MAX)
                                                            : frame_width_r;
  assign fh_eff = (frame_height_r > FRAME_BITS'(FRAME_MAX)) ? FRAME_BITS'(FRAME_MAX)
                                                            : frame_height_r;

  assign in_ready = !skid_valid_r;
  assign in_take  = in_valid && in_ready;

  cbl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_beat   (in_data),
    .frame_w   (fw_eff),
    .frame_h   (fh_eff),
    .res_valid (res_valid),
    .res       (res)
  );

  assign push = in_take && res_valid;
  assign pop  = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        // drain the skid beat, refill behind it
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = res;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = push;
      out_data_nxt  = res;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/cbl_checker.sv
module cbl_checker
  import cbl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input cbl_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input cbl_out_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // a new output beat comes only from a step beat taken the cycle before
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.op == OP_STEP))
    else $error("output beat without a step beat");

  // masked pixels report position zero
  a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pixel_write |-> out_data.pixel_x == '0 && out_data.pixel_y == '0)
    else $error("masked pixel carries a position");

  // an empty output side never backpressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind clipped_bresenham_line_generator cbl_checker u_cbl_checker (.*);

// File: tb/clipped_bresenham_line_generator_tb.sv
`timescale 1ns / 100ps

module clipped_bresenham_line_generator_tb;
  import cbl_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 6;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 170;
  localparam int PHASE_W [NUM_PHASES] = '{320, 1024, 1, 2047, 0, 640, 64, 1024, 200};
  localparam int PHASE_H [NUM_PHASES] = '{200, 1024, 1, 2047, 5, 480, 48, 1024, 1000};

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  cbl_in_t           in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  cbl_out_t          out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  cbl_in_t  line_items[$];
  cbl_out_t pixel_beats_due[$];

  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  in_gap         = 0;
  int  ready_hold     = 0;
  int  phase_items    = 0;
  bit  steady_in      = 1'b0;
  bit  steady_out     = 1'b0;

  // line walker state
  int  frame_w = 320;
  int  frame_h = 200;
  bit  line_on = 1'b0;
  int  cur_x = 0, cur_y = 0;
  int  err_acc = 0;
  int  run_major = 0, run_minor = 0;
  int  dir_x = 0, dir_y = 0;
  bit  major_is_x = 1'b0;
  int  steps_to_go = 0;
  int  dash_count = 0;
  int  dash_len = 1;
  logic [COLOR_BITS-1:0] pen = '0;
  int  clip_l = 0, clip_r = 0, clip_t = 0, clip_b = 0;

  clipped_bresenham_line_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk one accepted beat through the line state; queue the pixel it yields.
  task automatic bresenham_advance(input cbl_in_t it);
    int fwe, fhe, x1, y1, x2, y2, dx, dy, ax, ay;
    bit dash_hit, in_clip, is_last;
    cbl_out_t px;
    fwe = (frame_w > FRAME_MAX) ? FRAME_MAX : frame_w;
    fhe = (frame_h > FRAME_MAX) ? FRAME_MAX : frame_h;
    if (it.op == OP_LOAD) begin
      x1 = int'($signed(it.start_x));
      y1 = int'($signed(it.start_y));
      x2 = int'($signed(it.end_x));
      y2 = int'($signed(it.end_y));
      // drop loads that reach past the frame
      if (x1 > fwe || x2 > fwe || y1 > fhe || y2 > fhe) return;
      dx = x2 - x1;
      dy = y2 - y1;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      dir_x = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
      dir_y = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
      major_is_x = (ax >= ay);
      run_major = major_is_x ? ax : ay;
      run_minor = major_is_x ? ay : ax;
      err_acc = run_major >>> 1;
      cur_x = x1;
      cur_y = y1;
      steps_to_go = run_major;
      line_on = (run_major != 0);
      dash_len = (it.dash_skip == '0) ? 1 : int'(it.dash_skip);
      dash_count = 0;
      pen = it.pen_color;
      clip_l = int'($signed(it.box_left));
      clip_r = int'($signed(it.box_right));
      clip_t = int'($signed(it.box_top));
      clip_b = int'($signed(it.box_bottom));
    end else if (line_on) begin
      err_acc += run_minor;
      if (err_acc >= run_major) begin
        err_acc -= run_major;
        if (major_is_x) cur_y += dir_y;
        else cur_x += dir_x;
      end
      if (major_is_x) cur_x += dir_x;
      else cur_y += dir_y;
      dash_hit = (dash_count == 0);
      dash_count = (dash_count + 1 >= dash_len) ? 0 : dash_count + 1;
      in_clip = cur_x >= clip_l && cur_x <= clip_r && cur_y >= clip_t && cur_y <= clip_b &&
                cur_x >= 0 && cur_x < fwe && cur_y >= 0 && cur_y < fhe;
      steps_to_go -= 1;
      is_last = (steps_to_go <= 0);
      if (is_last) line_on = 1'b0;
      px = '0;
      if (dash_hit && in_clip) begin
        px.pixel_x = cur_x[PIX_BITS-1:0];
        px.pixel_y = cur_y[PIX_BITS-1:0];
        px.pixel_write = 1'b1;
      end
      px.pixel_color = pen;
      px.line_last = is_last;
      pixel_beats_due.push_back(px);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < -2048) return -12'sd2048;
    if (v > 2047) return 12'sd2047;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic cbl_in_t random_item();
    cbl_in_t it;
    it.op         = cbl_op_t'($urandom_range(0, 1));
    it.start_x    = COORD_BITS'($urandom);
    it.start_y    = COORD_BITS'($urandom);
    it.end_x      = COORD_BITS'($urandom);
    it.end_y      = COORD_BITS'($urandom);
    it.pen_color  = COLOR_BITS'($urandom);
    it.dash_skip  = SKIP_BITS'($urandom);
    it.box_left   = COORD_BITS'($urandom);
    it.box_right  = COORD_BITS'($urandom);
    it.box_top    = COORD_BITS'($urandom);
    it.box_bottom = COORD_BITS'($urandom);
    return it;
  endfunction

  // step beats carry random junk outside op
  function automatic cbl_in_t step_item();
    cbl_in_t it;
    it = random_item();
    it.op = OP_STEP;
    return it;
  endfunction

  function automatic cbl_in_t load_item(input int x1, input int y1, input int x2, input int y2,
                                        input int color, input int skip, input int bl,
                                        input int br, input int bt, input int bb);
    cbl_in_t it;
    it = random_item();
    it.op         = OP_LOAD;
    it.start_x    = clamp_coord(x1);
    it.start_y    = clamp_coord(y1);
    it.end_x      = clamp_coord(x2);
    it.end_y      = clamp_coord(y2);
    it.pen_color  = color[COLOR_BITS-1:0];
    it.dash_skip  = skip[SKIP_BITS-1:0];
    it.box_left   = clamp_coord(bl);
    it.box_right  = clamp_coord(br);
    it.box_top    = clamp_coord(bt);
    it.box_bottom = clamp_coord(bb);
    return it;
  endfunction

  // Queue one line command followed by roughly the steps it needs.
  task automatic add_line(input int fwe, input int fhe);
    int r, span, x1, y1, x2, y2, ax, ay, nsteps, lo_x, hi_x, lo_y, hi_y;
    cbl_in_t it;
    r = $urandom_range(0, 99);
    span = (r < 85) ? 24 : (r < 98) ? 120 : 400;
    x1 = int'($urandom_range(0, fwe + 20)) - 20;
    y1 = int'($urandom_range(0, fhe + 20)) - 20;
    x2 = x1 + int'($urandom_range(0, 2 * span)) - span;
    y2 = y1 + int'($urandom_range(0, 2 * span)) - span;
    if (x2 > fwe) x2 = fwe;
    if (y2 > fhe) y2 = fhe;
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 1) x2 = $urandom_range(fwe + 1, 2047);
      else y1 = $urandom_range(fhe + 1, 2047);
    end
    it = random_item();
    it.op        = OP_LOAD;
    it.start_x   = clamp_coord(x1);
    it.start_y   = clamp_coord(y1);
    it.end_x     = clamp_coord(x2);
    it.end_y     = clamp_coord(y2);
    r = $urandom_range(0, 99);
    it.dash_skip = (r < 40) ? SKIP_BITS'($urandom_range(0, 1)) :
                   (r < 80) ? SKIP_BITS'($urandom_range(2, 5)) : SKIP_BITS'($urandom);
    lo_x = (x1 < x2) ? x1 : x2;
    hi_x = (x1 < x2) ? x2 : x1;
    lo_y = (y1 < y2) ? y1 : y2;
    hi_y = (y1 < y2) ? y2 : y1;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      it.box_left   = -12'sd2048;
      it.box_right  = 12'sd2047;
      it.box_top    = -12'sd2048;
      it.box_bottom = 12'sd2047;
    end else if (r < 75) begin
      it.box_left   = clamp_coord(lo_x + int'($urandom_range(0, 10)) - 5);
      it.box_right  = clamp_coord(hi_x + int'($urandom_range(0, 10)) - 5);
      it.box_top    = clamp_coord(lo_y + int'($urandom_range(0, 10)) - 5);
      it.box_bottom = clamp_coord(hi_y + int'($urandom_range(0, 10)) - 5);
    end else if (r < 85) begin
      it.box_left   = clamp_coord(hi_x + 1 + int'($urandom_range(0, 20)));
      it.box_right  = clamp_coord(lo_x);
      it.box_top    = clamp_coord(lo_y);
      it.box_bottom = clamp_coord(hi_y);
    end
    line_items.push_back(it);
    ax = (x2 > x1) ? x2 - x1 : x1 - x2;
    ay = (y2 > y1) ? y2 - y1 : y1 - y2;
    nsteps = ((ax > ay) ? ax : ay) + int'($urandom_range(0, 2));
    // cut some lines short so the next load lands mid-line
    if ($urandom_range(0, 9) == 0) nsteps = $urandom_range(0, nsteps);
    repeat (nsteps) line_items.push_back(step_item());
    phase_items += 1 + nsteps;
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 3)) begin
      line_items.push_back(random_item());
      phase_items++;
    end
  endtask

  task automatic write_frame_reg(input cbl_reg_t idx, input int value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx) << 2;
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = value & 'h7FF;
    else frame_h = value & 'h7FF;
  endtask

  // Hold until every queued beat went in and every pixel came back, then let
  // the pipeline settle.
  task automatic drain();
    do @(negedge clk);
    while (line_items.size() != 0 || in_valid || pixel_beats_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) bresenham_advance(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0 && !steady_in) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (line_items.size() != 0) begin
          in_data  <= line_items.pop_front();
          in_valid <= 1'b1;
          in_gap   <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : pixel_monitor
    cbl_out_t want;
    int g;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_beats_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pixel beat: expected none, got x=%0d y=%0d color=%0d %s",
                   $time, out_data.pixel_x, out_data.pixel_y, out_data.pixel_color,
                   $sformatf("write=%0b last=%0b", out_data.pixel_write, out_data.line_last));
        end else begin
          want = pixel_beats_due.pop_front();
          if (out_data !== want) begin
            mismatch_count++;
            $display("%0t: pixel mismatch: expected x=%0d y=%0d color=%0d write=%0b last=%0b",
                     $time, want.pixel_x, want.pixel_y, want.pixel_color,
                     want.pixel_write, want.line_last);
            $display("%0t:                 got      x=%0d y=%0d color=%0d write=%0b last=%0b",
                     $time, out_data.pixel_x, out_data.pixel_y, out_data.pixel_color,
                     out_data.pixel_write, out_data.line_last);
          end
        end
      end
      if (steady_out) begin
        out_ready <= 1'b1;
      end else if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
      end else if (out_ready) begin
        g = pick_gap();
        if (g == 0) begin
          ready_hold <= $urandom_range(0, 8);
        end else begin
          out_ready  <= 1'b0;
          ready_hold <= g - 1;
        end
      end else begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 12);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("clipped_bresenham_line_generator_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int fwe, fhe;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // step with no line loaded
    line_items.push_back(step_item());
    // horizontal line, dash skip zero, walk one step past the end
    line_items.push_back(load_item(0, 0, 2, 0, 255, 0, -2048, 2047, -2048, 2047));
    repeat (3) line_items.push_back(step_item());
    // steep line going up and left, every other step
    line_items.push_back(load_item(10, 10, 9, 6, 0, 2, -2048, 2047, -2048, 2047));
    repeat (4) line_items.push_back(step_item());
    // zero-length line
    line_items.push_back(load_item(5, 5, 5, 5, 17, 1, -2048, 2047, -2048, 2047));
    line_items.push_back(step_item());
    // load past the frame edge must not disturb the active line
    line_items.push_back(load_item(0, 0, 2, 2, 100, 1, -2048, 2047, -2048, 2047));
    line_items.push_back(step_item());
    line_items.push_back(load_item(321, 0, 0, 0, 1, 1, -2048, 2047, -2048, 2047));
    repeat (2) line_items.push_back(step_item());
    // inverted clip box
    line_items.push_back(load_item(300, 190, 319, 199, 3, 1, 2047, -2048, 2047, -2048));
    repeat (2) line_items.push_back(step_item());
    // endpoint on the frame bound, longest dash period
    line_items.push_back(load_item(318, 198, 320, 200, 200, 255, -2048, 2047, -2048, 2047));
    repeat (2) line_items.push_back(step_item());
    // most negative coordinates
    line_items.push_back(load_item(-2048, -2048, -2047, -2048, 9, 1, -2048, 2047, -2048, 2047));
    line_items.push_back(step_item());
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      steady_in  = (p % 3 == 1);
      steady_out = (p % 3 == 2);
      write_frame_reg(REG_FRAME_WIDTH, PHASE_W[p]);
      write_frame_reg(REG_FRAME_HEIGHT, PHASE_H[p]);
      @(negedge clk);
      fwe = (frame_w > FRAME_MAX) ? FRAME_MAX : frame_w;
      fhe = (frame_h > FRAME_MAX) ? FRAME_MAX : frame_h;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) add_noise();
        else add_line(fwe, fhe);
      end
      drain();
    end

    if (mismatch_count == 0 && pixel_beats_due.size() == 0) begin
      $display("clipped_bresenham_line_generator_tb: done, clean");
    end else begin
      $display("clipped_bresenham_line_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
